/* src/plcr_pkg.sv */
// ----------------------------------------------------------------------------
// plcr_pkg - shared types and constants of the color ramp
// Field widths, register indexes and default sizes used by the top and the divider.
// ----------------------------------------------------------------------------
package plcr_pkg;

  localparam int MAX_KEYS_DEF    = 16;
  localparam int MAX_ENTRIES_DEF = 1024;

  localparam int HW    = 16;   // key height width
  localparam int CW    = 8;    // color channel width
  localparam int KIW   = 4;    // key_index field width
  localparam int IDXW  = 10;   // entry_index field width
  localparam int NKW   = 5;    // num_keys register width
  localparam int NEW   = 11;   // num_entries register width
  localparam int QW    = 16;   // weight fraction bits
  localparam int WW    = QW + 1;

  localparam logic [NKW-1:0] NUM_KEYS_RST    = NKW'(2);
  localparam logic [NEW-1:0] NUM_ENTRIES_RST = NEW'(256);
  localparam logic [WW-1:0]  W_ONE           = WW'(1) << QW;

  typedef enum logic {
    REG_NUM_KEYS    = 1'b0,
    REG_NUM_ENTRIES = 1'b1
  } reg_idx_t;

  typedef enum logic {
    ACT_WRITE_KEY = 1'b0,
    ACT_EVAL      = 1'b1
  } action_t;

endpackage

/* src/piecewise_linear_color_ramp_top.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_color_ramp_top - color ramp built from height/color keys
// Key writes fill the key table; evaluations search the bracketing keys
// and blend their colors by a division-derived weight.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  in_      in   in_tvalid/in_tready  tdata: key fields + entry_index, tuser: action
//  out_     out  out_tvalid/out_tready tdata: entry_number, red, green, blue
//  cfg_     in   APB psel/penable     num_keys @0x0, num_entries @0x4
//
// A key write is accepted while the sequencer stays idle. An evaluation steps through:
// accept, load the end heights and scale the entry index, a binary search of
// ceil(log2(num_keys-1)) steps, fetch and test the bracket, the weight, the
// one-bit-per-cycle divider, a blend of each channel on the shared 18x17
// multiplier, and the hand-off, in that order. A clamped weight skips the
// divider; a flat or falling bracket skips weight and blend. in_tready is high
// only while the sequencer is idle; a finished result waits in the output
// register while the next transaction is taken.
// Reset clears control state only; the key table holds nothing until written.
// ----------------------------------------------------------------------------
module piecewise_linear_color_ramp_top #(
  parameter int MAX_KEYS    = plcr_pkg::MAX_KEYS_DEF,
  parameter int MAX_ENTRIES = plcr_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // key_index[3:0], key_height[19:4], key_red[27:20], key_green[35:28],
  // key_blue[43:36], entry_index[53:44], zero fill
  input  logic [55:0] in_tdata,
  input  logic        in_tuser,   // action
  input  logic        in_tvalid,
  output logic        in_tready,
  // entry_number[9:0], red[17:10], green[25:18], blue[33:26], zero fill
  output logic [39:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import plcr_pkg::*;

  localparam int KW  = $clog2(MAX_KEYS);
  localparam int DW  = $clog2(MAX_ENTRIES);
  localparam int AW  = HW + 2;                               // multiplier a
  localparam int MBW = (DW > WW) ? ((DW > IDXW) ? DW : IDXW)
                                 : ((WW > IDXW) ? WW : IDXW); // multiplier b
  localparam int PW  = AW + MBW + 1;
  localparam int VW  = PW + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_H0, S_HN, S_M0, S_M1, S_M2, S_M3,
    S_SRCH, S_SRD, S_SCMP, S_LR, S_LR2,
    S_W1, S_W2, S_W3, S_W4, S_DIV,
    S_B0, S_B1, S_B2, S_FIN
  } state_t;

  // ---- input field unpack
  logic [KIW-1:0]  f_key_index;
  logic [HW-1:0]   f_key_height;
  logic [3*CW-1:0] f_key_color;
  logic [IDXW-1:0] f_entry_index;

  assign f_key_index   = in_tdata[3:0];
  assign f_key_height  = in_tdata[19:4];
  assign f_key_color   = {in_tdata[27:20], in_tdata[35:28], in_tdata[43:36]};
  assign f_entry_index = in_tdata[53:44];

  // ---- configuration registers
  logic [NKW-1:0] num_keys_r;
  logic [NEW-1:0] num_entries_r;
  logic           cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_keys_r    <= NUM_KEYS_RST;
      num_entries_r <= NUM_ENTRIES_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(cfg_paddr[2]))
        REG_NUM_KEYS:    num_keys_r    <= cfg_pwdata[NKW-1:0];
        REG_NUM_ENTRIES: num_entries_r <= cfg_pwdata[NEW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(cfg_paddr[2]))
      REG_NUM_KEYS:    cfg_prdata = 32'(num_keys_r);
      REG_NUM_ENTRIES: cfg_prdata = 32'(num_entries_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // Clamp the registers to the supported ranges
  logic [KW-1:0] nm1;
  logic [DW-1:0] dval;

  always_comb begin
    int nk_i;
    int ne_i;
    nk_i = int'(num_keys_r);
    ne_i = int'(num_entries_r);
    if (nk_i < 1)           nk_i = 1;
    if (nk_i > MAX_KEYS)    nk_i = MAX_KEYS;
    if (ne_i < 2)           ne_i = 2;
    if (ne_i > MAX_ENTRIES) ne_i = MAX_ENTRIES;
    nm1  = KW'(nk_i - 1);
    dval = DW'(ne_i - 1);
  end

  // ---- sequencer registers
  state_t                 state_r;
  logic [IDXW-1:0]        idx_r;
  logic [KW-1:0]          nm1_r;
  logic [DW-1:0]          d_r;
  logic signed [HW-1:0]   h0_r, hn_r, hl_r, hr_r;
  logic [3*CW-1:0]        cl_r, cr_r;
  logic signed [VW-1:0]   v_r, num_r, den_r;
  logic [KW-1:0]          l_r, r_r, m_r;
  logic [WW-1:0]          w_r;
  logic [1:0]             ch_r;
  logic [CW-1:0]          acc_r;
  logic [CW-1:0]          res_r [3];
  logic signed [PW-1:0]   prod_r;
  logic                   out_valid_r;
  logic [IDXW-1:0]        out_idx_r;
  logic [CW-1:0]          out_red_r, out_green_r, out_blue_r;

  // ---- key table
  logic                   key_we;
  logic [KW-1:0]          rd_addr;
  logic [HW-1:0]          h_rdata;
  logic [3*CW-1:0]        c_rdata;

  assign in_tready = (state_r == S_IDLE);
  assign key_we    = in_tvalid && in_tready && (action_t'(in_tuser) == ACT_WRITE_KEY)
                     && (int'(f_key_index) < MAX_KEYS);

  plcr_ram #(.WIDTH(HW), .DEPTH(MAX_KEYS)) u_height_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (KW'(f_key_index)),
    .wdata (f_key_height),
    .raddr (rd_addr),
    .rdata (h_rdata)
  );

  plcr_ram #(.WIDTH(3*CW), .DEPTH(MAX_KEYS)) u_color_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (KW'(f_key_index)),
    .wdata (f_key_color),
    .raddr (rd_addr),
    .rdata (c_rdata)
  );

  // ---- search midpoint
  logic [KW:0]   lr_sum;
  logic [KW:0]   lr_gap;
  logic [KW-1:0] mid;

  assign lr_sum = {1'b0, l_r} + {1'b0, r_r};
  assign lr_gap = {1'b0, r_r} - {1'b0, l_r};
  assign mid    = lr_sum[KW:1];

  always_comb begin
    unique case (state_r)
      S_HN:    rd_addr = nm1_r;
      S_SRCH:  rd_addr = (lr_gap > (KW+1)'(1)) ? mid : l_r;
      S_LR:    rd_addr = r_r;
      default: rd_addr = '0;
    endcase
  end

  // ---- channel select, R first
  logic [CW-1:0] cl_ch, cr_ch;

  always_comb begin
    case (ch_r)
      2'd0:    begin cl_ch = cl_r[23:16]; cr_ch = cr_r[23:16]; end
      2'd1:    begin cl_ch = cl_r[15:8];  cr_ch = cr_r[15:8];  end
      default: begin cl_ch = cl_r[7:0];   cr_ch = cr_r[7:0];   end
    endcase
  end

  // ---- shared multiplier, registered product
  logic signed [AW-1:0] mul_a;
  logic [MBW-1:0]       mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_M1: begin
        mul_a = AW'(hn_r) - AW'(h0_r);
        mul_b = MBW'(idx_r);
      end
      S_M2: begin
        mul_a = AW'(h0_r);
        mul_b = MBW'(d_r);
      end
      S_SRD: begin
        mul_a = AW'($signed(h_rdata));
        mul_b = MBW'(d_r);
      end
      S_W1: begin
        mul_a = AW'(hl_r);
        mul_b = MBW'(d_r);
      end
      S_W2: begin
        mul_a = AW'(hr_r) - AW'(hl_r);
        mul_b = MBW'(d_r);
      end
      S_B0: begin
        mul_a = $signed(AW'(cl_ch));
        mul_b = MBW'(W_ONE - w_r);
      end
      S_B1: begin
        mul_a = $signed(AW'(cr_ch));
        mul_b = MBW'(w_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * $signed({1'b0, mul_b});
  end

  // ---- divider
  logic          div_start;
  logic          div_done;
  logic [QW-1:0] div_quot;

  assign div_start = (state_r == S_W4) && (num_r > 0) && (num_r < den_r);

  plcr_div #(.W(VW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  logic [CW:0] blend_sum;
  assign blend_sum = {1'b0, acc_r} + {1'b0, prod_r[QW +: CW]};

  logic out_valid_nxt;
  logic fin_load;

  assign fin_load      = (state_r == S_FIN) && (!out_valid_r || out_tready);
  assign out_valid_nxt = fin_load ? 1'b1 : (out_valid_r && !out_tready);

  // ---- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && (action_t'(in_tuser) == ACT_EVAL)) begin
            idx_r   <= f_entry_index;
            nm1_r   <= nm1;
            d_r     <= dval;
            state_r <= S_H0;
          end
        end
        S_H0: state_r <= S_HN;
        S_HN: begin
          h0_r    <= $signed(h_rdata);
          state_r <= S_M0;
        end
        S_M0: begin
          hn_r    <= $signed(h_rdata);
          state_r <= S_M1;
        end
        S_M1: state_r <= S_M2;
        S_M2: begin
          v_r     <= VW'(prod_r);
          state_r <= S_M3;
        end
        S_M3: begin
          v_r     <= v_r + VW'(prod_r);
          l_r     <= '0;
          r_r     <= nm1_r;
          state_r <= S_SRCH;
        end
        S_SRCH: begin
          if (lr_gap > (KW+1)'(1)) begin
            m_r     <= mid;
            state_r <= S_SRD;
          end else begin
            state_r <= S_LR;
          end
        end
        S_SRD: state_r <= S_SCMP;
        S_SCMP: begin
          // step toward the bracket that holds the scaled value
          if (VW'(prod_r) <= v_r) begin
            l_r <= m_r;
          end else begin
            r_r <= m_r;
          end
          state_r <= S_SRCH;
        end
        S_LR: begin
          hl_r    <= $signed(h_rdata);
          cl_r    <= c_rdata;
          state_r <= S_LR2;
        end
        S_LR2: begin
          hr_r    <= $signed(h_rdata);
          cr_r    <= c_rdata;
          state_r <= S_W1;
        end
        S_W1: begin
          if (hr_r <= hl_r) begin
            // flat or falling bracket: left color as is
            res_r[0] <= cl_r[23:16];
            res_r[1] <= cl_r[15:8];
            res_r[2] <= cl_r[7:0];
            state_r  <= S_FIN;
          end else begin
            state_r <= S_W2;
          end
        end
        S_W2: begin
          num_r   <= v_r - VW'(prod_r);
          state_r <= S_W3;
        end
        S_W3: begin
          den_r   <= VW'(prod_r);
          state_r <= S_W4;
        end
        S_W4: begin
          ch_r <= 2'd0;
          if (num_r <= 0) begin
            w_r     <= '0;
            state_r <= S_B0;
          end else if (num_r >= den_r) begin
            w_r     <= W_ONE;
            state_r <= S_B0;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            w_r     <= WW'(div_quot);
            state_r <= S_B0;
          end
        end
        S_B0: state_r <= S_B1;
        S_B1: begin
          acc_r   <= prod_r[QW +: CW];
          state_r <= S_B2;
        end
        S_B2: begin
          res_r[ch_r] <= blend_sum[CW] ? {CW{1'b1}} : blend_sum[CW-1:0];
          if (ch_r == 2'd2) begin
            state_r <= S_FIN;
          end else begin
            ch_r    <= ch_r + 2'd1;
            state_r <= S_B0;
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (fin_load) begin
            out_idx_r   <= idx_r;
            out_red_r   <= res_r[0];
            out_green_r <= res_r[1];
            out_blue_r  <= res_r[2];
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_blue_r, out_green_r, out_red_r, out_idx_r};

`ifndef ASSERT_OFF
  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (num_r > 0) && (num_r < den_r))
    else $error("divider started outside its range");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider done outside the divide state");

  a_bracket_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> (l_r <= r_r))
    else $error("search bracket crossed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> out_valid_r)
    else $error("pending result dropped");
`endif

endmodule

/* src/plcr_ram.sv */
// ----------------------------------------------------------------------------
// plcr_ram - generic single write, single read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module plcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

/* src/plcr_div.sv */
// ----------------------------------------------------------------------------
// plcr_div - restoring fraction divider
// Produces floor(num * 2^QW / den) for 0 < num < den, one bit per cycle.
// ----------------------------------------------------------------------------
module plcr_div #(
  parameter int W = 36
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [W-1:0]        num,
  input  logic [W-1:0]        den,
  output logic                done,
  output logic [plcr_pkg::QW-1:0] quot
);
  import plcr_pkg::*;

  localparam int CNTW = $clog2(QW + 1);

  logic [W-1:0]    rem_r;
  logic [QW-1:0]   quot_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [W:0]      shl;
  logic            ge;

  assign shl  = {rem_r, 1'b0};
  assign ge   = shl >= {1'b0, den};
  assign done = done_r;
  assign quot = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? W'(shl - {1'b0, den}) : shl[W-1:0];
      quot_r <= {quot_r[QW-2:0], ge};
    end
  end

endmodule
